// ===== hdl/scf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scf_pkg: shared types and constants of the 3x3 cross sharpening filter
// Field widths, register codes, reset values and the job record that the
// front hands to the back through the job queue.
// ----------------------------------------------------------------------------
package scf_pkg;

	localparam int SAMPLE_W   = 8;
	localparam int SAMPLE_MAX = 255;
	localparam int ROW_W      = 16;
	localparam int OUT_COL_W  = 11;
	localparam int CH_W       = 2;
	localparam int SUM_W      = 12;

	localparam int IMG_W_W    = 12;
	localparam int IMG_H_W    = 16;
	localparam int CH_CNT_W   = 3;
	localparam int MIN_DIM    = 3;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [IMG_W_W-1:0]  RST_IMAGE_WIDTH   = 12'd640;
	localparam logic [IMG_H_W-1:0]  RST_IMAGE_HEIGHT  = 16'd480;
	localparam logic [CH_CNT_W-1:0] RST_CHANNEL_COUNT = 3'd3;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_IMAGE_HEIGHT  = 2'd1,
		REG_CHANNEL_COUNT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [IMG_W_W-1:0]  image_width;
		logic [IMG_H_W-1:0]  image_height;
		logic [CH_CNT_W-1:0] channel_count;
	} cfg_t;

	// One queued job: the five taps of the cross and the bookkeeping of
	// the result (and of the optional bottom-row zero that follows it).
	typedef struct packed {
		logic [SAMPLE_W-1:0]  center;
		logic [SAMPLE_W-1:0]  left;
		logic [SAMPLE_W-1:0]  right;
		logic [SAMPLE_W-1:0]  upper;
		logic [SAMPLE_W-1:0]  lower;
		logic [ROW_W-1:0]     row;
		logic [OUT_COL_W-1:0] column;
		logic [CH_W-1:0]      channel;
		logic                 interior;
		logic                 bottom;
		logic                 done;
	} job_t;

	typedef enum logic {
		PH_MAIN   = 1'b0,
		PH_BOTTOM = 1'b1
	} phase_t;

endpackage
`default_nettype wire

// ===== hdl/scf_stream_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scf_in_if / scf_out_if: valid/ready channels of the sharpening filter
// The sample channel carries raster-order samples, the result channel the
// sharpened samples with their position.
// ----------------------------------------------------------------------------
interface scf_in_if import scf_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] sample;
	logic                frame_start;

	modport source (output valid, output sample, output frame_start, input ready);
	modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

interface scf_out_if import scf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [SAMPLE_W-1:0]  pixel_value;
	logic [ROW_W-1:0]     out_row;
	logic [OUT_COL_W-1:0] out_column;
	logic [CH_W-1:0]      out_channel;
	logic                 run_last;
	logic                 frame_done;

	modport source (output valid, output pixel_value, output out_row, output out_column,
		output out_channel, output run_last, output frame_done, input ready);
	modport sink   (input valid, input pixel_value, input out_row, input out_column,
		input out_channel, input run_last, input frame_done, output ready);
endinterface
`default_nettype wire

// ===== hdl/scf_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scf_front: sample intake, position counters and line stores
// Accepts samples, tracks row, column and channel, reads the line stores
// and the recent window, classifies the item and pushes a job.
// ----------------------------------------------------------------------------
module scf_front import scf_pkg::*; #(
	parameter int MAX_WIDTH    = 2048,
	parameter int MAX_CHANNELS = 4
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire cfg_t  cfg,
	scf_in_if.sink     samples,
	output logic       push,
	output job_t       push_job,
	input  wire logic  q_full
);

	localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
	localparam int AW     = $clog2(DEPTH);
	localparam int AW1    = AW + 1;
	localparam int CW     = $clog2(MAX_WIDTH);
	localparam int WEW    = (CW + 1 > IMG_W_W) ? CW + 1 : IMG_W_W;
	localparam int PW     = CW + 3;
	localparam int WIN_IW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int WIN_D  = 1 << WIN_IW;

	// Line stores: upper holds row r-2, middle holds row r-1.
	logic [SAMPLE_W-1:0] upper_mem  [DEPTH];
	logic [SAMPLE_W-1:0] middle_mem [DEPTH];
	logic [SAMPLE_W-1:0] win_q      [WIN_D];

	logic [ROW_W-1:0] row_q;
	logic [CW-1:0]    col_q;
	logic [CH_W-1:0]  ch_q;

	logic [WEW-1:0]      w_eff;
	logic [IMG_H_W-1:0]  h_eff;
	logic [CH_CNT_W-1:0] n_eff;

	logic [ROW_W-1:0]    row_e;
	logic [CW-1:0]       col_e;
	logic [CH_W-1:0]     ch_e;
	logic [ROW_W:0]      row_p1;
	logic [WEW-1:0]      col_p1;
	logic [CH_CNT_W-1:0] ch_p1;
	logic                row_last, col_last, ch_last;
	logic [PW-1:0]       prod;
	logic [AW-1:0]       j;
	logic [AW:0]         jr_sum;
	logic [AW-1:0]       jr;
	logic                accept, s1_done;
	logic                is_row0, is_main;

	logic                 s1_valid_q;
	logic [AW-1:0]        j_s1;
	logic [WIN_IW-1:0]    lidx_s1;
	logic [SAMPLE_W-1:0]  lower_s1, up_rd_s1, mid_rd_s1, right_rd_s1;
	logic                 has_first_s1, interior_s1, bottom_s1, done_s1;
	logic [ROW_W-1:0]     row_s1;
	logic [OUT_COL_W-1:0] col_s1;
	logic [CH_W-1:0]      ch_s1;

	// Effective geometry after clamping.
	always_comb begin
		w_eff = WEW'(cfg.image_width);
		if (w_eff < WEW'(MIN_DIM)) begin
			w_eff = WEW'(MIN_DIM);
		end else if (w_eff > WEW'(MAX_WIDTH)) begin
			w_eff = WEW'(MAX_WIDTH);
		end
		h_eff = cfg.image_height;
		if (h_eff < IMG_H_W'(MIN_DIM)) begin
			h_eff = IMG_H_W'(MIN_DIM);
		end
		n_eff = cfg.channel_count;
		if (n_eff == '0) begin
			n_eff = CH_CNT_W'(1);
		end else if (n_eff > CH_CNT_W'(MAX_CHANNELS)) begin
			n_eff = CH_CNT_W'(MAX_CHANNELS);
		end
	end

	// Position of the incoming sample and its line store addresses.
	always_comb begin
		row_e    = samples.frame_start ? '0 : row_q;
		col_e    = samples.frame_start ? '0 : col_q;
		ch_e     = samples.frame_start ? '0 : ch_q;
		row_p1   = {1'b0, row_e} + (ROW_W+1)'(1);
		col_p1   = WEW'(col_e) + WEW'(1);
		ch_p1    = CH_CNT_W'(ch_e) + CH_CNT_W'(1);
		row_last = row_p1 >= {1'b0, h_eff};
		col_last = col_p1 >= w_eff;
		ch_last  = ch_p1 >= n_eff;
		is_row0  = row_e == '0;
		is_main  = row_e >= ROW_W'(2);
		prod     = PW'(col_e) * PW'(n_eff) + PW'(ch_e);
		j        = prod[AW-1:0];
		jr_sum   = {1'b0, j} + AW1'(n_eff);
		jr       = (jr_sum >= AW1'(DEPTH)) ? AW'(jr_sum - AW1'(DEPTH)) : jr_sum[AW-1:0];
	end

	assign s1_done       = s1_valid_q && (!has_first_s1 || !q_full);
	assign samples.ready = !s1_valid_q || s1_done;
	assign accept        = samples.valid && samples.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q      <= '0;
			col_q      <= '0;
			ch_q       <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
				if (ch_last) begin
					ch_q <= '0;
					if (col_last) begin
						col_q <= '0;
						row_q <= row_last ? '0 : row_p1[ROW_W-1:0];
					end else begin
						col_q <= CW'(col_p1);
						row_q <= row_e;
					end
				end else begin
					ch_q  <= ch_p1[CH_W-1:0];
					col_q <= col_e;
					row_q <= row_e;
				end
			end else if (s1_done) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	// Stage 1 bookkeeping, captured at the transfer.
	always_ff @(posedge clk) begin
		if (accept) begin
			j_s1         <= j;
			lidx_s1      <= WIN_IW'(n_eff - CH_CNT_W'(1));
			lower_s1     <= samples.sample;
			has_first_s1 <= is_row0 || is_main;
			interior_s1  <= is_main && (col_e != '0) && (col_p1 < w_eff) && (row_e < h_eff);
			bottom_s1    <= is_main && row_last;
			done_s1      <= col_last && ch_last;
			row_s1       <= is_row0 ? '0 : row_e - ROW_W'(1);
			col_s1       <= OUT_COL_W'(col_e);
			ch_s1        <= ch_e;
		end
	end

	// Line stores: reads registered at the transfer, middle written with
	// the new sample, upper written with the old middle when stage 1 completes.
	always_ff @(posedge clk) begin
		if (accept) begin
			up_rd_s1       <= upper_mem[j];
			mid_rd_s1      <= middle_mem[j];
			right_rd_s1    <= middle_mem[jr];
			middle_mem[j]  <= samples.sample;
		end
		if (s1_done) begin
			upper_mem[j_s1] <= mid_rd_s1;
		end
	end

	// Recent middle-row samples; the left neighbour sits one pixel back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < WIN_D; k++) begin
				win_q[k] <= '0;
			end
		end else if (s1_done) begin
			win_q[0] <= mid_rd_s1;
			for (int k = 1; k < WIN_D; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
	end

	assign push = s1_valid_q && has_first_s1 && !q_full;

	always_comb begin
		push_job.center   = mid_rd_s1;
		push_job.left     = win_q[lidx_s1];
		push_job.right    = right_rd_s1;
		push_job.upper    = up_rd_s1;
		push_job.lower    = lower_s1;
		push_job.row      = row_s1;
		push_job.column   = col_s1;
		push_job.channel  = ch_s1;
		push_job.interior = interior_s1;
		push_job.bottom   = bottom_s1;
		push_job.done     = done_s1;
	end

endmodule
`default_nettype wire

// ===== hdl/scf_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scf_queue: short job queue between front and back
// Lets the front keep taking samples while the back waits on its output.
// ----------------------------------------------------------------------------
module scf_queue import scf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	output logic      full,
	input  wire logic pop,
	output job_t      head,
	output logic      head_valid
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign full       = count_q == QCNT_W'(QUEUE_DEPTH);
	assign head_valid = count_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("job pushed into a full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("job popped from an empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH)) else $error("queue count past its depth");

endmodule
`default_nettype wire

// ===== hdl/scf_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// scf_back: kernel arithmetic and result output register
// Takes jobs from the queue, forms 5*centre minus the four neighbours with
// saturation, and emits one or two results per job.
// ----------------------------------------------------------------------------
module scf_back import scf_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t head,
	input  wire logic head_valid,
	output logic      pop,
	scf_out_if.source results
);

	phase_t               phase_q, phase_d;
	logic                 out_valid_q;
	logic [SAMPLE_W-1:0]  pixel_q;
	logic [ROW_W-1:0]     row_q;
	logic [OUT_COL_W-1:0] col_q;
	logic [CH_W-1:0]      ch_q;
	logic                 run_last_q, done_q;
	logic                 out_free, load;
	logic [SUM_W-1:0]     acc;
	logic [SAMPLE_W-1:0]  main_val;

	always_comb begin
		acc = (SUM_W'(head.center) << 2) + SUM_W'(head.center) - SUM_W'(head.left)
			- SUM_W'(head.right) - SUM_W'(head.upper) - SUM_W'(head.lower);
		if (!head.interior || acc[SUM_W-1]) begin
			main_val = '0;
		end else if (acc > SUM_W'(SAMPLE_MAX)) begin
			main_val = SAMPLE_W'(SAMPLE_MAX);
		end else begin
			main_val = acc[SAMPLE_W-1:0];
		end
	end

	assign out_free = !out_valid_q || results.ready;
	assign load     = head_valid && out_free;

	always_comb begin
		phase_d = phase_q;
		pop     = 1'b0;
		case (phase_q)
			PH_MAIN: begin
				if (load) begin
					if (head.bottom) begin
						phase_d = PH_BOTTOM;
					end else begin
						pop = 1'b1;
					end
				end
			end
			PH_BOTTOM: begin
				if (load) begin
					phase_d = PH_MAIN;
					pop     = 1'b1;
				end
			end
			default: begin
				phase_d = PH_MAIN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MAIN;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (out_free) begin
				out_valid_q <= head_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			col_q <= head.column;
			ch_q  <= head.channel;
			if (phase_q == PH_BOTTOM) begin
				pixel_q    <= '0;
				row_q      <= head.row + ROW_W'(1);
				run_last_q <= 1'b1;
				done_q     <= head.done;
			end else begin
				pixel_q    <= main_val;
				row_q      <= head.row;
				run_last_q <= !head.bottom;
				done_q     <= 1'b0;
			end
		end
	end

	assign results.valid       = out_valid_q;
	assign results.pixel_value = pixel_q;
	assign results.out_row     = row_q;
	assign results.out_column  = col_q;
	assign results.out_channel = ch_q;
	assign results.run_last    = run_last_q;
	assign results.frame_done  = done_q;

	a_bottom_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BOTTOM |-> head_valid && head.bottom)
		else $error("bottom-row phase without a pending bottom job");
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.frame_done |-> results.run_last)
		else $error("frame end flagged on a result that is not the last of its sample");

endmodule
`default_nettype wire

// ===== hdl/sharpen_3x3_cross_filter_top.sv =====
// Path: stage 1 registers, then the job queue, then the output register of the back.
// Throughput: one sample per cycle while the job queue is not full; on the last row each
// sample gives two results, emitted in turn by the single output register of the back.
// Reset: counters, window, job queue and output valid clear; registers return to 640/480/3.
// The line stores are not cleared and there is no clearing pass after reset.
`default_nettype none
// ----------------------------------------------------------------------------
// sharpen_3x3_cross_filter_top: streaming 3x3 cross sharpening filter
// Applies the kernel 0,-1,0 / -1,5,-1 / 0,-1,0 to raster-order interleaved
// 8-bit samples, giving zero on the border rows and columns.
// ----------------------------------------------------------------------------
module sharpen_3x3_cross_filter_top import scf_pkg::*; #(
	parameter int MAX_WIDTH    = 2048,
	parameter int MAX_CHANNELS = 4
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	scf_in_if.sink                     samples,
	scf_out_if.source                  results
);

	// The front owns the position counters and the two line stores. A
	// sample transfer reads the upper line, the middle line at the same
	// place and the middle line one pixel to the right; the middle line
	// takes the new sample in the same cycle. When stage 1 completes, the old
	// middle sample moves to the upper line and into the short window
	// that supplies the left neighbour, and its job, if any, goes into the queue.
	//
	// The back pops jobs, does the kernel arithmetic and drives the
	// result register. A job from the last interior row carries a second
	// result, the zero of the bottom row, which the back emits right after
	// the main one. Since the queue sits between them, the front keeps
	// taking samples while a result waits for its transfer, until the queue fills.

	cfg_t cfg_q;
	logic push, q_full, pop, head_valid;
	job_t push_job, head;

	// Configuration registers; a write to an index past the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_width   <= RST_IMAGE_WIDTH;
			cfg_q.image_height  <= RST_IMAGE_HEIGHT;
			cfg_q.channel_count <= RST_CHANNEL_COUNT;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:   cfg_q.image_width   <= cfg_data[IMG_W_W-1:0];
				REG_IMAGE_HEIGHT:  cfg_q.image_height  <= cfg_data[IMG_H_W-1:0];
				REG_CHANNEL_COUNT: cfg_q.channel_count <= cfg_data[CH_CNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	scf_front #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.samples  (samples),
		.push     (push),
		.push_job (push_job),
		.q_full   (q_full)
	);

	scf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	scf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.results    (results)
	);

endmodule
`default_nettype wire
